>>> src/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants for the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam logic [7:0] SymPlus  = 8'h2B;
  localparam logic [7:0] SymMinus = 8'h2D;
  localparam logic [7:0] SymMul   = 8'h2A;
  localparam logic [7:0] SymDiv   = 8'h2F;
  localparam logic [7:0] SymZero  = 8'h30;
  localparam logic [7:0] SymNine  = 8'h39;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StUnderflow = 3'd1;
  localparam logic [2:0] StBadChar   = 3'd2;
  localparam logic [2:0] StDivZero   = 3'd3;
  localparam logic [2:0] StOverflow  = 3'd4;
  localparam logic [2:0] StDepth     = 3'd5;
  localparam logic [2:0] StSaturated = 3'd6;

  typedef enum logic [2:0] {
    OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_BAD
  } op_t;

  // classified beat handed from front to back
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       is_last;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_LD, S_EXEC, S_DIV, S_FIN, S_OUT
  } state_t;

endpackage

>>> src/pfe_if.sv
// ----------------------------------------------------------------------------
// pfe_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface pfe_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// accepts symbols, classifies them, and queues commands for the back end
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  symbol,
  input  logic        is_last,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        cmd_valid,
  output pfe_pkg::cmd_t cmd,
  input  logic        cmd_ready
);
  pfe_pkg::cmd_t q [2];
  logic [1:0]    cnt;
  logic          wptr, rptr;
  pfe_pkg::cmd_t c;
  logic          push, pop;

  always_comb begin
    c.is_last = is_last;
    c.digit   = 4'(symbol - pfe_pkg::SymZero);
    if (symbol >= pfe_pkg::SymZero && symbol <= pfe_pkg::SymNine) c.op = pfe_pkg::OP_PUSH;
    else if (symbol == pfe_pkg::SymPlus)  c.op = pfe_pkg::OP_ADD;
    else if (symbol == pfe_pkg::SymMinus) c.op = pfe_pkg::OP_SUB;
    else if (symbol == pfe_pkg::SymMul)   c.op = pfe_pkg::OP_MUL;
    else if (symbol == pfe_pkg::SymDiv)   c.op = pfe_pkg::OP_DIV;
    else c.op = pfe_pkg::OP_BAD;
  end

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; wptr <= 1'b0; rptr <= 1'b0;
    end else begin
      if (push) begin
        q[wptr] <= c;
        wptr    <= ~wptr;
      end
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> src/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div
// restoring divider: (a << 16) / b truncated, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfe_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [48:0] quo
);
  logic [47:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem[31:0], num[47]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd48;
        num  <= {(a[31] ? 32'(-a) : 32'(a)), 16'd0};
        den  <= b[31] ? 32'(-b) : 32'(b);
        neg  <= a[31] ^ b[31];
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? trial - {1'b0, den} : trial;
        num <= {num[46:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed({1'b0, num}) : $signed({1'b0, num});
endmodule

>>> src/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// executes commands against the operand stack and builds results
// ----------------------------------------------------------------------------
module pfe_back #(
  parameter int StackDepth = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pfe_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [2:0]         status
);
  localparam int AW = $clog2(StackDepth);
  localparam int TW = $clog2(StackDepth + 1);

  pfe_pkg::state_t state, state_next;
  pfe_pkg::cmd_t   cur;
  logic [TW-1:0]   top;
  logic [2:0]      err;
  logic signed [31:0] op1, op2;
  logic signed [63:0] prod;
  logic            mul_wait;

  logic            we;
  logic [AW-1:0]   addr;
  logic [31:0]     wdata, rdata;

  logic            div_start, div_done;
  logic signed [48:0] quo;

  pfe_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk, .we, .addr, .wdata, .rdata
  );

  pfe_div u_div (
    .clk, .rst, .start(div_start), .a(op2), .b(op1), .done(div_done), .quo
  );

  function automatic logic [32:0] sat(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return {1'b1, 32'h7FFFFFFF};
    if (v < -65'sd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, v[31:0]};
  endfunction

  logic accept, ready_op, do_push;
  logic [32:0] alu;
  logic signed [64:0] raw;

  assign cmd_ready = (state == pfe_pkg::S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign ready_op  = (err == pfe_pkg::StOk);

  always_comb begin
    case (cur.op)
      pfe_pkg::OP_ADD: raw = 65'(op2) + 65'(op1);
      pfe_pkg::OP_SUB: raw = 65'(op2) - 65'(op1);
      pfe_pkg::OP_MUL: raw = 65'(prod >>> 16);
      default:         raw = 65'(quo);
    endcase
    alu = sat(raw);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfe_pkg::S_IDLE: if (accept) begin
        if (cmd.op == pfe_pkg::OP_ADD || cmd.op == pfe_pkg::OP_SUB ||
            cmd.op == pfe_pkg::OP_MUL || cmd.op == pfe_pkg::OP_DIV) begin
          if (err == pfe_pkg::StOk && top >= TW'(2) && top <= TW'(StackDepth))
            state_next = pfe_pkg::S_RD1;
          else state_next = pfe_pkg::S_FIN;
        end else state_next = pfe_pkg::S_FIN;
      end
      pfe_pkg::S_RD1: state_next = pfe_pkg::S_RD2;
      pfe_pkg::S_RD2: state_next = pfe_pkg::S_LD;
      pfe_pkg::S_LD:  state_next = pfe_pkg::S_EXEC;
      pfe_pkg::S_EXEC: begin
        if (mul_wait && cur.op == pfe_pkg::OP_DIV && op1 != 32'sd0)
          state_next = pfe_pkg::S_DIV;
        else if (mul_wait && cur.op == pfe_pkg::OP_MUL) state_next = pfe_pkg::S_EXEC;
        else state_next = pfe_pkg::S_FIN;
      end
      pfe_pkg::S_DIV: if (div_done) state_next = pfe_pkg::S_EXEC;
      pfe_pkg::S_FIN: state_next = cur.is_last ? pfe_pkg::S_OUT : pfe_pkg::S_IDLE;
      pfe_pkg::S_OUT: if (out_ready) state_next = pfe_pkg::S_IDLE;
      default: state_next = pfe_pkg::S_IDLE;
    endcase
  end

  // outputs: ram port and divider start
  always_comb begin
    we = 1'b0; addr = '0; wdata = alu[31:0]; div_start = 1'b0; do_push = 1'b0;
    case (state)
      pfe_pkg::S_IDLE: begin
        do_push = accept && cmd.op == pfe_pkg::OP_PUSH && ready_op && top < TW'(StackDepth);
        we    = do_push;
        addr  = AW'(top);
        wdata = {12'd0, cmd.digit, 16'd0};
      end
      pfe_pkg::S_RD1: addr = AW'(top - TW'(1));
      pfe_pkg::S_RD2: addr = AW'(top - TW'(2));
      pfe_pkg::S_EXEC: begin
        addr = AW'(top - TW'(2));
        div_start = mul_wait && cur.op == pfe_pkg::OP_DIV && op1 != 32'sd0;
        we = !(mul_wait && (cur.op == pfe_pkg::OP_DIV || cur.op == pfe_pkg::OP_MUL));
      end
      pfe_pkg::S_FIN: addr = '0;
      default: ;
    endcase
  end

  // mul_wait marks the first exec cycle: mul registers its product, div starts
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfe_pkg::S_IDLE; top <= '0; err <= pfe_pkg::StOk; mul_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        pfe_pkg::S_IDLE: if (accept) begin
          cur <= cmd;
          if (ready_op) begin
            case (cmd.op)
              pfe_pkg::OP_PUSH:
                if (do_push) top <= top + TW'(1);
                else err <= pfe_pkg::StOverflow;
              pfe_pkg::OP_BAD: err <= pfe_pkg::StBadChar;
              default:
                if (!(top >= TW'(2) && top <= TW'(StackDepth))) err <= pfe_pkg::StUnderflow;
            endcase
          end
        end
        pfe_pkg::S_RD2: begin
          op1 <= rdata; mul_wait <= 1'b1;
        end
        pfe_pkg::S_EXEC: begin
          if (cur.op == pfe_pkg::OP_MUL && mul_wait) begin
            prod <= op2 * op1; mul_wait <= 1'b0;
          end else if (cur.op == pfe_pkg::OP_DIV && mul_wait && op1 == 32'sd0) begin
            err <= pfe_pkg::StDivZero;
          end else if (cur.op == pfe_pkg::OP_DIV && mul_wait) begin
            mul_wait <= 1'b0;
          end else begin
            top <= top - TW'(1);
            if (alu[32]) err <= pfe_pkg::StSaturated;
          end
        end
        pfe_pkg::S_FIN: if (cur.is_last) begin
          out_valid <= 1'b1;
          status <= (err == pfe_pkg::StOk && top != TW'(1)) ? pfe_pkg::StDepth : err;
        end
        pfe_pkg::S_OUT: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
      if (state == pfe_pkg::S_FIN && cur.is_last) begin
        top <= '0; err <= pfe_pkg::StOk;
      end
    end
  end

  // op2 arrives from the second read, registered in S_LD
  logic op2_load;
  always_ff @(posedge clk) begin
    if (rst) op2_load <= 1'b0;
    else op2_load <= (state == pfe_pkg::S_RD2);
    if (op2_load) op2 <= rdata;
  end

  // value of entry zero captured once its read lands, the cycle after S_FIN
  logic fin_d;
  always_ff @(posedge clk) begin
    if (rst) fin_d <= 1'b0;
    else fin_d <= (state == pfe_pkg::S_FIN) && cur.is_last;
  end

  logic signed [31:0] val_q;
  always_ff @(posedge clk) begin
    if (fin_d) val_q <= (status == pfe_pkg::StOk) ? rdata : 32'sd0;
  end
  assign value = fin_d ? ((status == pfe_pkg::StOk) ? rdata : 32'sd0) : val_q;
endmodule

>>> src/postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// reverse polish calculator over signed q16.16 values
// ----------------------------------------------------------------------------
// back end steps per beat from accept: a digit, bad char or ignored beat goes
// to S_FIN; add/sub run S_RD1, S_RD2, S_LD, S_EXEC, S_FIN; mul repeats S_EXEC
// for its product register; div waits in S_DIV on the divider; result in S_OUT
// throughput: one beat at a time in the back end; a 2-entry queue decouples it
// reset: rst synchronous active high, clears stack pointer, error and queues;
// stack ram contents are not cleared
module postfix_expression_evaluator_unit #(
  parameter int StackDepth = 64
) (
  input logic clk,
  input logic rst,
  pfe_if.sink   in_ch,
  pfe_if.source out_ch
);
  // front end: classify beats into commands
  logic          cmd_valid, cmd_ready;
  pfe_pkg::cmd_t cmd;
  logic [31:0]   value;
  logic [2:0]    status;

  pfe_front u_front (
    .clk, .rst,
    .symbol(in_ch.data.symbol), .is_last(in_ch.data.is_last),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .cmd_valid, .cmd, .cmd_ready
  );

  // back end: stack, alu and divider
  pfe_back #(.StackDepth(StackDepth)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .value, .status
  );

  assign out_ch.data.value  = value;
  assign out_ch.data.status = status;
endmodule
